[hdl/nodal_matrix_stamper_defines.svh]
// ----------------------------------------------------------------------------
// nodal matrix stamper assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NODAL_MATRIX_STAMPER_DEFINES_SVH
`define NODAL_MATRIX_STAMPER_DEFINES_SVH
`ifndef SYNTHESIS
`define NMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nms assertion failed");
`define NMS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nms reset assertion failed");
`else
`define NMS_ASSERT(lbl, clk, rstn, prop)
`define NMS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[hdl/nms_pkg.sv]
// ----------------------------------------------------------------------------
// nms_pkg
// types, constants and helpers of the nodal matrix stamper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nms_pkg;
  localparam int MAX_NODES = 16;
  localparam int MAT_COLS  = MAX_NODES + 1;
  localparam int MAT_DEPTH = MAX_NODES * MAT_COLS;
  localparam int AW        = $clog2(MAT_DEPTH);

  localparam logic       OP_STAMP  = 1'b0;
  localparam logic       OP_READ   = 1'b1;
  localparam logic [1:0] KIND_RES  = 2'd0;
  localparam logic [1:0] KIND_CUR  = 2'd1;
  localparam logic [4:0] NODES_MAX = 5'(MAX_NODES);
  localparam logic signed [47:0] ENTRY_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ENTRY_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic              operation;
    logic [1:0]        element_kind;
    logic [4:0]        node_pos;
    logic [4:0]        node_neg;
    logic signed [31:0] element_value;
    logic [3:0]        read_row;
    logic [4:0]        read_col;
    logic              final_element;
  } nms_in_t;

  typedef struct packed {
    logic signed [47:0] entry_value;
    logic               is_read;
    logic               done_res;
  } nms_out_t;

  typedef enum logic [1:0] {CMD_NOP, CMD_RES, CMD_CUR, CMD_READ} nms_kind_t;

  typedef struct packed {
    nms_kind_t          kind;
    logic               fin;
    logic [4:0]         np;
    logic [4:0]         nn;
    logic [4:0]         n;
    logic signed [31:0] val;
    logic [AW-1:0]      raddr;
    logic               rd_ok;
  } nms_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nms_fifo_stat_t;

  typedef struct packed {
    logic clearing;
  } nms_back_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_DIV, BK_STEP, BK_RD, BK_WR, BK_OUT
  } nms_bk_state_t;

  function automatic logic [AW-1:0] mat_addr(input logic [3:0] row, input logic [4:0] col);
    mat_addr = AW'({row, 4'b0000}) + AW'(row) + AW'(col);
  endfunction
endpackage
`default_nettype wire

[hdl/nms_fifo.sv]
// ----------------------------------------------------------------------------
// nms_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nms_fifo import nms_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire nms_cmd_t push_data,
  input  wire logic     pop,
  output nms_cmd_t      pop_data,
  output nms_fifo_stat_t stat
);
  nms_cmd_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign pop_data   = mem_r[rp_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
endmodule
`default_nettype wire

[hdl/nms_front.sv]
// ----------------------------------------------------------------------------
// nms_front
// holds node_count, accepts words and classifies them into commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nms_front import nms_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [4:0] cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire nms_in_t   in_data,
  input  wire nms_fifo_stat_t fifo_stat,
  input  wire nms_back_stat_t back_stat,
  output logic           push,
  output nms_cmd_t       cmd
);
  logic [4:0] node_count_r, node_count_nxt;
  logic [4:0] n;

  always_comb node_count_nxt = cfg_we ? cfg_wdata : node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= NODES_MAX;
    else        node_count_r <= node_count_nxt;
  end

  always_comb begin
    if (node_count_r == 5'd0)          n = 5'd1;
    else if (node_count_r > NODES_MAX) n = NODES_MAX;
    else                               n = node_count_r;
  end

  assign in_ready = !fifo_stat.full && !back_stat.clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    cmd.fin   = in_data.final_element;
    cmd.np    = in_data.node_pos;
    cmd.nn    = in_data.node_neg;
    cmd.n     = n;
    cmd.val   = in_data.element_value;
    cmd.raddr = mat_addr(in_data.read_row, in_data.read_col);
    cmd.rd_ok = ({1'b0, in_data.read_row} < n) && (in_data.read_col <= n);
    if (in_data.operation == OP_READ) begin
      cmd.kind = CMD_READ;
    end else if (in_data.node_pos > n || in_data.node_neg > n) begin
      cmd.kind = CMD_NOP;
    end else begin
      case (in_data.element_kind)
        KIND_RES: cmd.kind = CMD_RES;
        KIND_CUR: cmd.kind = CMD_CUR;
        default:  cmd.kind = CMD_NOP;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/nms_recip.sv]
// ----------------------------------------------------------------------------
// nms_recip
// restoring divider, 2^32 / mag, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nms_recip (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] mag,
  output logic             done,
  output logic [32:0]      quo
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, mag_r, mag_nxt;
  logic [32:0] q_r, q_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    trial    = {rem_r, cnt_r == 6'd33};
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    mag_nxt  = mag_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = 6'd33;
      rem_nxt = 32'd0;
      q_nxt   = 33'd0;
      mag_nxt = mag;
    end else if (cnt_r != 6'd0) begin
      if (trial >= {1'b0, mag_r}) begin
        rem_nxt = 32'(trial - {1'b0, mag_r});
        q_nxt   = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[31:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = cnt_r == 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    mag_r <= mag_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

[hdl/nms_back.sv]
// ----------------------------------------------------------------------------
// nms_back
// executes commands: matrix store, read-modify-write updates, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nodal_matrix_stamper_defines.svh"
module nms_back import nms_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire nms_cmd_t  fifo_data,
  input  wire nms_fifo_stat_t fifo_stat,
  output logic           pop,
  output nms_back_stat_t stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output nms_out_t       out_data
);
  logic signed [47:0] mem [MAT_DEPTH];
  logic signed [47:0] rdata_r;

  nms_bk_state_t state_r, state_nxt;
  nms_cmd_t      cmd_r, cmd_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [2:0]    step_r, step_nxt;
  logic signed [47:0] d_r, d_nxt;
  nms_out_t      res_r, res_nxt, out_r, out_nxt;
  logic          ov_r, ov_nxt;

  logic          div_start, div_done;
  logic [32:0]   quo;
  logic [31:0]   mag;

  logic          st_en, st_neg;
  logic [3:0]    st_row;
  logic [4:0]    st_col;
  logic [3:0]    rp, rn;
  logic          mem_we;
  logic [AW-1:0] raddr, waddr;
  logic signed [47:0] wdata, delta;
  logic signed [48:0] sum;
  logic          out_free;

  // divisor is taken from the word being popped, as the divider starts then
  assign mag = fifo_data.val[31] ? 32'(-fifo_data.val) : 32'(fifo_data.val);

  nms_recip u_recip (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .mag  (mag),
    .done (div_done),
    .quo  (quo)
  );

  assign rp = 4'(cmd_r.np - 5'd1);
  assign rn = 4'(cmd_r.nn - 5'd1);

  // update schedule of the current stamp
  always_comb begin
    st_en  = 1'b0;
    st_neg = 1'b0;
    st_row = rp;
    st_col = {1'b0, rp};
    if (cmd_r.kind == CMD_RES) begin
      case (step_r)
        3'd0: begin
          st_en = cmd_r.np != 5'd0;
        end
        3'd1: begin
          st_en = cmd_r.nn != 5'd0; st_row = rn; st_col = {1'b0, rn};
        end
        3'd2: begin
          st_en = cmd_r.np != 5'd0 && cmd_r.nn != 5'd0;
          st_neg = 1'b1; st_row = rn; st_col = {1'b0, rp};
        end
        3'd3: begin
          st_en = cmd_r.np != 5'd0 && cmd_r.nn != 5'd0;
          st_neg = 1'b1; st_col = {1'b0, rn};
        end
        default: st_en = 1'b0;
      endcase
    end else if (cmd_r.kind == CMD_CUR) begin
      case (step_r)
        3'd0: begin
          st_en = cmd_r.np != 5'd0; st_col = cmd_r.n;
        end
        3'd1: begin
          st_en = cmd_r.nn != 5'd0; st_neg = 1'b1; st_row = rn; st_col = cmd_r.n;
        end
        default: st_en = 1'b0;
      endcase
    end
  end

  assign delta = st_neg ? -d_r : d_r;
  assign sum   = {rdata_r[47], rdata_r} + {delta[47], delta};
  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_r == AW'(MAT_DEPTH - 1)) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          case (fifo_data.kind)
            CMD_READ: state_nxt = fifo_data.rd_ok ? BK_RD : BK_OUT;
            CMD_RES:  state_nxt = fifo_data.val == 32'sd0 ? BK_STEP : BK_DIV;
            CMD_CUR:  state_nxt = BK_STEP;
            default:  state_nxt = fifo_data.fin ? BK_OUT : BK_IDLE;
          endcase
        end
      end
      BK_DIV:  if (div_done) state_nxt = BK_STEP;
      BK_STEP: begin
        if (step_r == 3'd4)  state_nxt = cmd_r.fin ? BK_OUT : BK_IDLE;
        else if (st_en)      state_nxt = BK_RD;
      end
      BK_RD:   state_nxt = BK_WR;
      BK_WR:   state_nxt = cmd_r.kind == CMD_READ ? BK_OUT : BK_STEP;
      BK_OUT:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = state_r == BK_IDLE && !fifo_stat.empty;
    div_start = pop && fifo_data.kind == CMD_RES && fifo_data.val != 32'sd0;
    mem_we    = 1'b0;
    waddr     = clr_r;
    wdata     = 48'sd0;
    raddr     = cmd_r.kind == CMD_READ ? cmd_r.raddr : mat_addr(st_row, st_col);
    if (state_r == BK_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == BK_WR && cmd_r.kind != CMD_READ) begin
      mem_we = 1'b1;
      waddr  = mat_addr(st_row, st_col);
      if (sum[48] != sum[47]) wdata = sum[48] ? ENTRY_MIN : ENTRY_MAX;
      else                    wdata = sum[47:0];
    end
  end

  always_comb begin
    cmd_nxt  = cmd_r;
    clr_nxt  = clr_r;
    step_nxt = step_r;
    d_nxt    = d_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    ov_nxt   = ov_r && !out_ready;
    if (state_r == BK_CLEAR) clr_nxt = clr_r + AW'(1);
    if (pop) begin
      cmd_nxt  = fifo_data;
      step_nxt = 3'd0;
      d_nxt    = fifo_data.kind == CMD_RES ? ENTRY_MAX : 48'(fifo_data.val);
      res_nxt  = '{entry_value: 48'sd0, is_read: fifo_data.kind == CMD_READ,
                   done_res: fifo_data.kind != CMD_READ};
    end
    if (state_r == BK_DIV && div_done)
      d_nxt = cmd_r.val[31] ? -48'(quo) : 48'(quo);
    if (state_r == BK_STEP && !st_en && step_r != 3'd4) step_nxt = step_r + 3'd1;
    if (state_r == BK_WR) begin
      step_nxt = step_r + 3'd1;
      if (cmd_r.kind == CMD_READ) res_nxt.entry_value = rdata_r;
    end
    if (state_r == BK_OUT && out_free) begin
      out_nxt = res_r;
      ov_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    step_r <= step_nxt;
    d_r    <= d_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign stat.clearing = state_r == BK_CLEAR;
  assign out_valid     = ov_r;
  assign out_data      = out_r;

  `NMS_ASSERT(a_no_pop_in_clear, clk, rst_n, (state_r == BK_CLEAR) |-> !pop)
  `NMS_ASSERT(a_waddr_in_range, clk, rst_n, mem_we |-> (waddr < AW'(MAT_DEPTH)))
  `NMS_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> (state_r == BK_DIV))
  `NMS_ASSERT(a_clear_ends_idle, clk, rst_n, (state_r == BK_CLEAR && clr_r == AW'(MAT_DEPTH - 1)) |=> (state_r == BK_IDLE))
  `NMS_ASSERT_RST(a_reset_clears, clk, !rst_n |=> (state_r == BK_CLEAR && !ov_r))
endmodule
`default_nettype wire

[hdl/nodal_matrix_stamper.sv]
// ----------------------------------------------------------------------------
// nodal_matrix_stamper
// assembles the augmented nodal matrix of a dc circuit from stamp words
// ----------------------------------------------------------------------------
// usage:
//   in_*  : valid/ready channel of nms_in_t words, stamp or read
//   out_* : valid/ready channel of nms_out_t words, one per read and one
//           done word per stamp carrying final_element
//   cfg_* : write enable and data of node_count, written while idle
// sequence: a resistor stamp of nonzero value first passes the divider (one
//   quotient bit per cycle), then makes up to four matrix updates, each
//   through BK_STEP, BK_RD and BK_WR, before any done word; a current
//   stamp makes up to two updates; an in-range read passes BK_RD and BK_WR
// flow: the back end handles one word at a time; the front queue holds
//   two words so input keeps flowing until the queue fills
// reset: node_count returns to 16 and the 272-entry store is cleared one
//   entry a cycle, during which in_ready stays low
// stall: a waiting result sits in the output register; the back end stops
//   before its next result and the queue then fills and drops in_ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nodal_matrix_stamper import nms_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire nms_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output nms_out_t        out_data
);
  nms_cmd_t       push_cmd, pop_cmd;
  logic           push, pop;
  nms_fifo_stat_t fifo_stat;
  nms_back_stat_t back_stat;

  nms_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fifo_stat(fifo_stat),
    .back_stat(back_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  nms_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_cmd),
    .pop      (pop),
    .pop_data (pop_cmd),
    .stat     (fifo_stat)
  );

  nms_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fifo_data(pop_cmd),
    .fifo_stat(fifo_stat),
    .pop      (pop),
    .stat     (back_stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );
endmodule
`default_nettype wire
